/* src/kfd_pkg.sv */
// Shared types and constants for the keypad frame deframer and decoder.
// Used by kfd_decode and keypad_frame_deframer_decoder; no dependencies.
package kfd_pkg;

  // Message kinds carried on the result channel.
  typedef enum logic [1:0] {
    MSG_TEACHER = 2'd0,
    MSG_STUDENT = 2'd1,
    MSG_SET_ID  = 2'd2
  } msg_kind_t;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ID_W     = 9;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned ANS_W    = 3;

  // Decode constants.
  localparam logic [KEY_W-1:0]  KEY_KNOWN_LIMIT = 7'd12;
  localparam logic [ANS_W-1:0]  ANS_RUSH        = 3'd6;
  localparam logic [BYTE_W-1:0] SHORT_TEACHER   = 8'd0;
  localparam logic [BYTE_W-1:0] SHORT_MAX_ID    = 8'd100;
  localparam logic [BYTE_W-1:0] SHORT_SET_ID    = 8'd121;
  localparam logic [1:0]        CLASS_TEACHER   = 2'd0;
  localparam logic [1:0]        CLASS_STUDENT   = 2'd1;
  localparam logic [1:0]        CLASS_SET_ID    = 2'd2;
  localparam logic [2:0]        SUB_SET_ID      = 3'd0;

  // One decoded result item.
  typedef struct packed {
    msg_kind_t          kind;
    logic [ID_W-1:0]    keypad_id;
    logic [KEY_W-1:0]   teacher_key;
    logic               key_known;
    logic [ANS_W-1:0]   answer;
    logic [KEY_W-1:0]   first;
    logic [BYTE_W-1:0]  second;
    logic [BYTE_W-1:0]  check;
  } result_t;

endpackage

/* src/keypad_frame_deframer_decoder.sv */
// Keypad frame deframer and decoder: one received byte per transfer.
// A result is loaded into the output register when the byte that completes it is taken, or into the skid entry if not.
// Throughput: one byte per cycle while in_stall is low; a result register plus one skid entry absorb stalls.
// in_stall rises only while the skid entry is occupied.
// Synchronous active-low reset empties the byte window and both result registers
// and clears short_format. Depends on kfd_pkg and kfd_decode.
module keypad_frame_deframer_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_short_format,
  // Byte input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kfd_pkg::BYTE_W-1:0]       in_byte_in,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_message_kind,
  output logic [kfd_pkg::ID_W-1:0]         out_keypad_id,
  output logic [kfd_pkg::KEY_W-1:0]        out_teacher_key,
  output logic                             out_teacher_key_known,
  output logic [kfd_pkg::ANS_W-1:0]        out_answer_choice,
  output logic [kfd_pkg::KEY_W-1:0]        out_frame_first,
  output logic [kfd_pkg::BYTE_W-1:0]       out_frame_second,
  output logic [kfd_pkg::BYTE_W-1:0]       out_frame_check
);

  logic                          short_format_r;
  logic [kfd_pkg::BYTE_W-1:0]    win0_r, win0_nxt;
  logic [kfd_pkg::BYTE_W-1:0]    win1_r, win1_nxt;
  logic [1:0]                    fill_r, fill_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          skid_valid_r, skid_valid_nxt;
  kfd_pkg::result_t              out_res_r, skid_res_r;
  kfd_pkg::result_t              dec_res;
  logic                          dec_known;
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          win_full;
  logic                          frame_ok;
  logic                          new_result;
  logic                          load_out;
  logic                          load_skid;
  logic                          skid_to_out;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_format_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      short_format_r <= cfg_short_format;
    end
  end

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // A fill count of two or more means the window is full.
  assign win_full = fill_r[1];
  assign frame_ok = win_full && !win0_r[7] && (in_byte_in == (win0_r ^ win1_r));

  kfd_decode u_decode (
    .short_format (short_format_r),
    .b0           (win0_r),
    .b1           (win1_r),
    .b2           (in_byte_in),
    .known        (dec_known),
    .res          (dec_res)
  );

  // Window update: fill, consume a good frame, or slide by one byte.
  always_comb begin
    win0_nxt = win0_r;
    win1_nxt = win1_r;
    fill_nxt = fill_r;
    if (in_xfer) begin
      if (!win_full) begin
        if (fill_r[0]) begin
          win1_nxt = in_byte_in;
        end else begin
          win0_nxt = in_byte_in;
        end
        fill_nxt = fill_r + 2'd1;
      end else if (frame_ok) begin
        win0_nxt = '0;
        win1_nxt = '0;
        fill_nxt = 2'd0;
      end else begin
        win0_nxt = win1_r;
        win1_nxt = in_byte_in;
        fill_nxt = 2'd2;
      end
    end
  end

  // Result routing between the output register and the skid entry.
  assign new_result  = in_xfer && frame_ok && dec_known;
  assign skid_to_out = skid_valid_r && (out_xfer || !out_valid_r);
  assign load_out    = new_result && !skid_valid_r && (out_xfer || !out_valid_r);
  assign load_skid   = new_result && !load_out;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_to_out) begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    if (load_skid) begin
      skid_valid_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r       <= '0;
      win1_r       <= '0;
      fill_r       <= 2'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      win0_r       <= win0_nxt;
      win1_r       <= win1_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (skid_to_out) begin
      out_res_r <= skid_res_r;
    end else if (load_out) begin
      out_res_r <= dec_res;
    end
    if (load_skid) begin
      skid_res_r <= dec_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_message_kind      = out_res_r.kind;
  assign out_keypad_id         = out_res_r.keypad_id;
  assign out_teacher_key       = out_res_r.teacher_key;
  assign out_teacher_key_known = out_res_r.key_known;
  assign out_answer_choice     = out_res_r.answer;
  assign out_frame_first       = out_res_r.first;
  assign out_frame_second      = out_res_r.second;
  assign out_frame_check       = out_res_r.check;

endmodule

/* src/kfd_decode.sv */
// Combinational decoder for one checked three-byte keypad frame.
// Depends on kfd_pkg for the result type and decode constants.
module kfd_decode (
  input  logic                         short_format,
  input  logic [kfd_pkg::BYTE_W-1:0]   b0,
  input  logic [kfd_pkg::BYTE_W-1:0]   b1,
  input  logic [kfd_pkg::BYTE_W-1:0]   b2,
  output logic                         known,
  output kfd_pkg::result_t             res
);

  logic [kfd_pkg::KEY_W-1:0] low7;
  logic [1:0]                c1;
  logic [4:0]                k1;
  logic [2:0]                c2;
  logic [3:0]                k2;
  logic [kfd_pkg::ANS_W-1:0] low7_ans;
  logic [kfd_pkg::ANS_W-1:0] c2_ans;

  assign low7 = b1[6:0];
  assign c1   = b0[6:5];
  assign k1   = b0[4:0];
  assign c2   = b1[6:4];
  assign k2   = b1[3:0];

  // Answer codes of six or above collapse to the rush code.
  assign low7_ans = (low7 < 7'd6) ? low7[2:0] : kfd_pkg::ANS_RUSH;
  assign c2_ans   = (c2 < kfd_pkg::ANS_RUSH) ? c2 : kfd_pkg::ANS_RUSH;

  // Pick the message kind and its fields for the selected format.
  always_comb begin
    known           = 1'b0;
    res.kind        = kfd_pkg::MSG_TEACHER;
    res.keypad_id   = '0;
    res.teacher_key = '0;
    res.key_known   = 1'b0;
    res.answer      = '0;
    res.first       = b0[6:0];
    res.second      = b1;
    res.check       = b2;
    if (short_format) begin
      if (b0 == kfd_pkg::SHORT_TEACHER) begin
        known           = 1'b1;
        res.kind        = kfd_pkg::MSG_TEACHER;
        res.teacher_key = low7;
        res.key_known   = (low7 < kfd_pkg::KEY_KNOWN_LIMIT);
      end else if (b0 <= kfd_pkg::SHORT_MAX_ID) begin
        known         = 1'b1;
        res.kind      = kfd_pkg::MSG_STUDENT;
        res.keypad_id = {1'b0, b0};
        res.answer    = low7_ans;
      end else if (b0 == kfd_pkg::SHORT_SET_ID) begin
        known         = 1'b1;
        res.kind      = kfd_pkg::MSG_SET_ID;
        res.keypad_id = {2'b00, low7};
      end
    end else begin
      if (c1 == kfd_pkg::CLASS_TEACHER && k1 == 5'd0) begin
        known           = 1'b1;
        res.kind        = kfd_pkg::MSG_TEACHER;
        res.teacher_key = low7;
        res.key_known   = (low7 < kfd_pkg::KEY_KNOWN_LIMIT);
      end else if (c1 == kfd_pkg::CLASS_STUDENT) begin
        known         = 1'b1;
        res.kind      = kfd_pkg::MSG_STUDENT;
        res.keypad_id = {k1, k2};
        res.answer    = c2_ans;
      end else if (c1 == kfd_pkg::CLASS_SET_ID && c2 == kfd_pkg::SUB_SET_ID) begin
        known         = 1'b1;
        res.kind      = kfd_pkg::MSG_SET_ID;
        res.keypad_id = {k1, k2};
      end
    end
  end

endmodule

/* sim/keypad_frame_checker.sv */
// Checker for the keypad frame deframer and decoder: watches the byte, result and
// configuration channels, predicts each decoded message and compares it with the block.
// Depends on kfd_pkg for the result struct, message kinds and decode constants.
`timescale 1ns / 100ps

module keypad_frame_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_short_format,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [kfd_pkg::BYTE_W-1:0] in_byte_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_message_kind,
  input  logic [kfd_pkg::ID_W-1:0]   out_keypad_id,
  input  logic [kfd_pkg::KEY_W-1:0]  out_teacher_key,
  input  logic                       out_teacher_key_known,
  input  logic [kfd_pkg::ANS_W-1:0]  out_answer_choice,
  input  logic [kfd_pkg::KEY_W-1:0]  out_frame_first,
  input  logic [kfd_pkg::BYTE_W-1:0] out_frame_second,
  input  logic [kfd_pkg::BYTE_W-1:0] out_frame_check,
  output int                         fail_count,
  output int                         pending_count
);
  import kfd_pkg::*;

  // Shadow copy of the block's byte window and format register.
  logic [7:0] window [2];
  logic [1:0] fill;
  logic       short_fmt;
  result_t    expected_msgs [$];
  int         errors;

  assign fail_count = errors;

  // Decode a frame that passed the check; returns 0 for an unknown code.
  function automatic logic decode_msg(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, output result_t msg);
    logic [6:0] low7;
    logic [1:0] cls;
    logic [4:0] id_hi;
    logic [2:0] sub;
    logic [3:0] id_lo;
    logic       hit;
    low7  = b1[6:0];
    cls   = b0[6:5];
    id_hi = b0[4:0];
    sub   = b1[6:4];
    id_lo = b1[3:0];
    hit   = 1'b1;
    msg        = '0;
    msg.first  = b0[6:0];
    msg.second = b1;
    msg.check  = b2;
    if (short_fmt) begin
      if (b0 == SHORT_TEACHER) begin
        msg.kind        = MSG_TEACHER;
        msg.teacher_key = low7;
        msg.key_known   = (low7 < KEY_KNOWN_LIMIT);
      end else if (b0 <= SHORT_MAX_ID) begin
        msg.kind      = MSG_STUDENT;
        msg.keypad_id = {1'b0, b0};
        msg.answer    = (low7 < ANS_RUSH) ? low7[2:0] : ANS_RUSH;
      end else if (b0 == SHORT_SET_ID) begin
        msg.kind      = MSG_SET_ID;
        msg.keypad_id = {2'b00, low7};
      end else begin
        hit = 1'b0;
      end
    end else begin
      if (cls == CLASS_TEACHER && id_hi == 5'd0) begin
        msg.kind        = MSG_TEACHER;
        msg.teacher_key = low7;
        msg.key_known   = (low7 < KEY_KNOWN_LIMIT);
      end else if (cls == CLASS_STUDENT) begin
        msg.kind      = MSG_STUDENT;
        msg.keypad_id = {id_hi, id_lo};
        msg.answer    = (sub < ANS_RUSH) ? sub : ANS_RUSH;
      end else if (cls == CLASS_SET_ID && sub == SUB_SET_ID) begin
        msg.kind      = MSG_SET_ID;
        msg.keypad_id = {id_hi, id_lo};
      end else begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // Push one received byte through the window; returns 1 when a message results.
  function automatic logic take_byte(input logic [7:0] b, output result_t msg);
    logic [1:0] held;
    logic [7:0] b0;
    logic [7:0] b1;
    held = (fill == 2'd3) ? 2'd2 : fill;
    b0   = window[0];
    b1   = window[1];
    msg  = '0;
    if (held < 2'd2) begin
      window[held[0]] = b;
      fill = held + 2'd1;
      return 1'b0;
    end
    // A good frame is consumed whole; a bad one drops only its oldest byte.
    if (!b0[7] && b == (b0 ^ b1)) begin
      fill      = 2'd0;
      window[0] = 8'd0;
      window[1] = 8'd0;
      return decode_msg(b0, b1, b, msg);
    end
    window[0] = b1;
    window[1] = b;
    fill      = 2'd2;
    return 1'b0;
  endfunction

  // Track transfers on all three channels at each rising edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t nxt;
    if (!rst_n) begin
      window[0] = 8'd0;
      window[1] = 8'd0;
      fill      = 2'd0;
      short_fmt = 1'b0;
      errors    = 0;
      expected_msgs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        short_fmt = cfg_short_format;
      end
      // Results are matched before this edge's byte is predicted.
      if (out_valid && !out_stall) begin
        got.kind        = msg_kind_t'(out_message_kind);
        got.keypad_id   = out_keypad_id;
        got.teacher_key = out_teacher_key;
        got.key_known   = out_teacher_key_known;
        got.answer      = out_answer_choice;
        got.first       = out_frame_first;
        got.second      = out_frame_second;
        got.check       = out_frame_check;
        if (expected_msgs.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected result kind=%0d id=%0d key=%0d bytes=%h %h %h",
                     $realtime, got.kind, got.keypad_id, got.teacher_key,
                     got.first, got.second, got.check);
          end
          errors++;
        end else begin
          want = expected_msgs.pop_front();
          if (got.kind !== want.kind || got.keypad_id !== want.keypad_id ||
              got.teacher_key !== want.teacher_key || got.key_known !== want.key_known ||
              got.answer !== want.answer || got.first !== want.first ||
              got.second !== want.second || got.check !== want.check) begin
            if (errors < 10) begin
              $display("%0t: mismatch expected kind=%0d id=%0d key=%0d known=%0b ans=%0d %h %h %h",
                       $realtime, want.kind, want.keypad_id, want.teacher_key,
                       want.key_known, want.answer, want.first, want.second, want.check);
              $display("%0t:          actual kind=%0d id=%0d key=%0d known=%0b ans=%0d %h %h %h",
                       $realtime, got.kind, got.keypad_id, got.teacher_key,
                       got.key_known, got.answer, got.first, got.second, got.check);
            end
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (take_byte(in_byte_in, nxt)) begin
          expected_msgs.push_back(nxt);
        end
      end
    end
    pending_count <= expected_msgs.size();
  end

endmodule

/* sim/keypad_frame_deframer_decoder_tb.sv */
// Testbench top for keypad_frame_deframer_decoder: drives bytes, register writes and
// result stalls, and gives the verdict. Depends on kfd_pkg and keypad_frame_checker.
`timescale 1ns / 100ps

module keypad_frame_deframer_decoder_tb;
  import kfd_pkg::*;

  // Well above the longest legal pause: a sender gap, chained stall bursts and the
  // drain before a register write all fit many times over.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 188;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_valid        = 1'b0;
  logic                cfg_short_format = 1'b0;
  logic                in_valid         = 1'b0;
  logic [BYTE_W-1:0]   in_byte_in       = '0;
  logic                out_stall        = 1'b0;
  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          out_message_kind;
  logic [ID_W-1:0]     out_keypad_id;
  logic [KEY_W-1:0]    out_teacher_key;
  logic                out_teacher_key_known;
  logic [ANS_W-1:0]    out_answer_choice;
  logic [KEY_W-1:0]    out_frame_first;
  logic [BYTE_W-1:0]   out_frame_second;
  logic [BYTE_W-1:0]   out_frame_check;
  int                  fail_count;
  int                  pending_count;
  int                  idle_cycles = 0;
  int                  bytes_sent  = 0;
  logic                cur_fmt     = 1'b0;
  logic                gaps_on     = 1'b1;
  logic                stall_on    = 1'b1;

  always #4 clk = ~clk;

  keypad_frame_deframer_decoder u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_short_format      (cfg_short_format),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_byte_in            (in_byte_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_message_kind      (out_message_kind),
    .out_keypad_id         (out_keypad_id),
    .out_teacher_key       (out_teacher_key),
    .out_teacher_key_known (out_teacher_key_known),
    .out_answer_choice     (out_answer_choice),
    .out_frame_first       (out_frame_first),
    .out_frame_second      (out_frame_second),
    .out_frame_check       (out_frame_check)
  );

  keypad_frame_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_short_format      (cfg_short_format),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_byte_in            (in_byte_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_message_kind      (out_message_kind),
    .out_keypad_id         (out_keypad_id),
    .out_teacher_key       (out_teacher_key),
    .out_teacher_key_known (out_teacher_key_known),
    .out_answer_choice     (out_answer_choice),
    .out_frame_first       (out_frame_first),
    .out_frame_second      (out_frame_second),
    .out_frame_check       (out_frame_check),
    .fail_count            (fail_count),
    .pending_count         (pending_count)
  );

  // Random stall bursts on the result channel.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL keypad_frame_deframer_decoder");
        $finish;
      end
    end
  end

  // One byte transfer, optionally preceded by an idle burst.
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // A frame with the given check byte.
  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2);
    send_byte(b0);
    send_byte(b1);
    send_byte(b2);
  endtask

  // Let the block drain every expected result, then wait out DRAIN_CYCLES as a margin.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the format register while the block is idle.
  task automatic write_format(input logic fmt);
    wait_quiet();
    cur_fmt          = fmt;
    cfg_valid        <= 1'b1;
    cfg_short_format <= fmt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with content aimed at the decode cases, plus noise.
  task automatic send_traffic(input int n_bytes);
    int         start;
    int         pick;
    logic [7:0] b0;
    logic [7:0] b1;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      b1 = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 2) == 0) begin
        b1[6:0] = 7'($urandom_range(0, 13));
      end
      if (cur_fmt) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0, 1:    b0 = SHORT_TEACHER;
          2, 3, 4: b0 = 8'($urandom_range(1, 100));
          5:       b0 = ($urandom_range(0, 1) == 0) ? SHORT_MAX_ID : SHORT_MAX_ID + 8'd1;
          6:       b0 = SHORT_SET_ID;
          default: b0 = 8'($urandom_range(0, 127));
        endcase
      end else begin
        b0 = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) begin
          b0[4:0] = 5'd0;
        end
        if ($urandom_range(0, 2) == 0) begin
          b1[6:4] = SUB_SET_ID;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(b0, b1, b0 ^ b1);
      end else if (pick < 87) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        send_frame(b0, b1, b0 ^ b1 ^ 8'($urandom_range(1, 255)));
      end else begin
        send_frame(b0 | 8'h80, b1, (b0 | 8'h80) ^ b1);
      end
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Packed format: a byte with its top bit set forces a resync into a teacher
    // frame, then student with rush and the largest id, set-id, and an unknown class.
    write_format(1'b0);
    send_byte(8'hC5);
    send_frame(8'h00, 8'h8B, 8'h8B);
    send_frame(8'h3F, 8'hFF, 8'hC0);
    send_frame(8'h5F, 8'h8F, 8'hD0);
    send_frame(8'h7F, 8'h00, 8'h7F);

    // Short format: a bad check byte, then an unknown teacher key, the highest
    // student id, set-id with the widest id, and an unknown first byte.
    write_format(1'b1);
    send_frame(8'h10, 8'h20, 8'h31);
    send_frame(8'h00, 8'h0C, 8'h0C);
    send_frame(8'h64, 8'h05, 8'h61);
    send_frame(8'h79, 8'h7F, 8'h06);
    send_frame(8'h65, 8'h00, 8'h65);

    // Random phases; the third one and the last one run without idle gaps or result stalls.
    for (phase = 0; phase < PHASES; phase++) begin
      gaps_on  = !(phase == 2 || phase == PHASES - 1);
      stall_on = gaps_on;
      if (phase == 0) begin
        write_format(1'b1);
      end else if (phase == 1) begin
        write_format(1'b0);
      end else begin
        write_format(1'($urandom_range(0, 1)));
      end
      send_traffic(PHASE_BYTES);
    end

    wait_quiet();
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS keypad_frame_deframer_decoder");
    end else begin
      $display("FAIL keypad_frame_deframer_decoder");
    end
    $finish;
  end

endmodule
